// ----- rtl/core/sktab_pkg.sv -----
// Shared types and codes for the sorted key table.
`timescale 1ns / 1ps
package sktab_pkg;
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EXISTS    = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam int FIELD_BITS = 7;
	localparam int KEY_PORT_BITS = 32;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic search;
		logic do_insert;
		logic do_delete;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic hit;
		logic full;
		logic nonempty;
	} stat_t;
endpackage

// ----- rtl/core/sorted_key_table_with_block_pool.sv -----
// Top level of the sorted key table with recycled block pool.
`timescale 1ns / 1ps
// Usage: commands (cmd, key) arrive on a valid/ready channel; each transfer
// yields one result (status, position, block_number, entry_count) on a
// valid/ready output channel. A row of key cells compares every stored key
// with the search key in parallel; the next cycle counts the keys below it,
// forms the result and shifts the rows for insert or delete.
// One command is in flight at a time: a new command is taken only once the
// previous result is formed. The result register holds its value while the
// receiver stalls, and no new command is taken until it is transferred.
// max_entries is written through cfg_we/cfg_data with no wait; values above
// DEPTH act as DEPTH, and zero makes every insert report full.
// Reset empties the table, returns slot i of the block pool to block i+1,
// and sets max_entries to 64. No clearing pass is needed.
// The datapath rows are flip-flops: keys, block numbers and a count.
module sorted_key_table_with_block_pool #(
	parameter int DEPTH = 64,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  position,
	output logic [6:0]  block_number,
	output logic [6:0]  entry_count,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data
);
	logic [6:0] max_entries_q;
	sktab_pkg::ctrl_t ctrl;
	sktab_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     max_entries_q <= 7'd64;
		else if (cfg_we) max_entries_q <= cfg_data;
	end

	sktab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
		.stat(stat), .ctrl(ctrl)
	);

	sktab_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .stat(stat), .cmd(cmd),
		.key(key), .max_entries(max_entries_q), .status(status),
		.position(position), .block_number(block_number),
		.entry_count(entry_count)
	);
endmodule

// ----- rtl/core/sktab_datapath.sv -----
// Row of key and block cells with parallel compare and shift.
`timescale 1ns / 1ps
module sktab_datapath #(
	parameter int DEPTH = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sktab_pkg::ctrl_t                     ctrl,
	output sktab_pkg::stat_t                     stat,
	input  logic [1:0]                           cmd,
	input  logic [sktab_pkg::KEY_PORT_BITS-1:0]  key,
	input  logic [sktab_pkg::FIELD_BITS-1:0]     max_entries,
	output logic [1:0]                           status,
	output logic [sktab_pkg::FIELD_BITS-1:0]     position,
	output logic [sktab_pkg::FIELD_BITS-1:0]     block_number,
	output logic [sktab_pkg::FIELD_BITS-1:0]     entry_count
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = $clog2(DEPTH + 2);
	localparam int KB = KEY_BITS;
	localparam int FB = sktab_pkg::FIELD_BITS;

	logic [KB-1:0] key_q [DEPTH];
	logic [BW-1:0] blk_q [DEPTH+1];
	logic [CW-1:0] count_q;
	logic [KB-1:0] k_q;
	logic [1:0]    cmd_q;

	logic [DEPTH-1:0] below_s1, equal_s1;
	logic [CW-1:0]    slot_s1;
	logic             hit_s1;

	logic [DEPTH-1:0] below_c, equal_c;
	logic [CW-1:0]    slot_c;
	logic [CW-1:0]    limit_c;
	logic [BW-1:0]    blk_at_slot;

	// Slots are sorted, so the insertion point is the number of keys below k.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			below_c[i] = (CW'(i) < count_q) && (key_q[i] < k_q);
			equal_c[i] = (CW'(i) < count_q) && (key_q[i] == k_q);
		end
	end

	// The below flags form one run starting at slot 0, so the highest set
	// flag gives the count.
	always_comb begin
		slot_c = '0;
		for (int i = 0; i < DEPTH; i++)
			if (below_s1[i]) slot_c = CW'(i + 1);
	end

	always_comb begin
		if (max_entries > FB'(DEPTH < (1 << FB) ? DEPTH : (1 << FB) - 1))
			limit_c = CW'(DEPTH);
		else
			limit_c = CW'(max_entries);
	end

	always_comb begin
		blk_at_slot = '0;
		for (int i = 0; i <= DEPTH; i++)
			if (CW'(i) == slot_s1) blk_at_slot = blk_q[i];
	end

	assign stat.hit = hit_s1;
	assign stat.full = (count_q >= limit_c);
	assign stat.nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			k_q <= key[KB-1:0];
			cmd_q <= cmd;
		end
		if (ctrl.search) begin
			below_s1 <= below_c;
			equal_s1 <= equal_c;
		end
	end

	// Slot count and hit resolved in the resolve state, from the registered compare flags.
	always_comb hit_s1 = |equal_s1;
	assign slot_s1 = slot_c;

	always_ff @(posedge clk) begin
		if (ctrl.do_insert) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (CW'(i) == slot_s1) key_q[i] <= k_q;
				else if (CW'(i) > slot_s1 && CW'(i) <= count_q && i > 0)
					key_q[i] <= key_q[(i > 0) ? i - 1 : 0];
			end
		end else if (ctrl.do_delete) begin
			for (int i = 0; i < DEPTH - 1; i++)
				if (CW'(i) >= slot_s1 && CW'(i) + 1'b1 < count_q)
					key_q[i] <= key_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= DEPTH; i++) blk_q[i] <= BW'(i + 1);
			count_q <= '0;
		end else begin
			if (ctrl.do_insert) begin
				for (int i = 0; i <= DEPTH; i++) begin
					if (CW'(i) == slot_s1) blk_q[i] <= blk_q[count_q];
					else if (CW'(i) > slot_s1 && CW'(i) <= count_q && i > 0)
						blk_q[i] <= blk_q[(i > 0) ? i - 1 : 0];
				end
				count_q <= count_q + 1'b1;
			end else if (ctrl.do_delete) begin
				for (int i = 0; i < DEPTH; i++) begin
					if (CW'(i) >= slot_s1 && CW'(i) + 1'b1 < count_q)
						blk_q[i] <= blk_q[i+1];
					else if (CW'(i) + 1'b1 == count_q)
						blk_q[i] <= blk_at_slot;
				end
				count_q <= count_q - 1'b1;
			end
		end
	end

	logic          resolve_q;
	logic [1:0]    st_c;
	logic [BW-1:0] bn_c;
	logic [CW-1:0] cnt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) resolve_q <= 1'b0;
		else         resolve_q <= ctrl.search;
	end

	always_comb begin
		st_c = sktab_pkg::ST_NOT_FOUND;
		bn_c = '0;
		cnt_c = count_q;
		unique case (cmd_q)
			sktab_pkg::CMD_INSERT: begin
				if (stat.full) st_c = sktab_pkg::ST_FULL;
				else if (hit_s1) begin
					st_c = sktab_pkg::ST_EXISTS;
					bn_c = blk_at_slot;
				end else begin
					st_c = sktab_pkg::ST_OK;
					bn_c = blk_q[count_q];
					cnt_c = count_q + 1'b1;
				end
			end
			sktab_pkg::CMD_DELETE: begin
				if (hit_s1) begin
					st_c = sktab_pkg::ST_OK;
					bn_c = blk_at_slot;
					cnt_c = count_q - 1'b1;
				end
			end
			default: begin
				if (hit_s1) begin
					st_c = sktab_pkg::ST_OK;
					bn_c = blk_at_slot;
				end
			end
		endcase
	end

	// The result register loads in the resolve cycle, from pre-update state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status <= sktab_pkg::ST_OK;
			position <= '0;
			block_number <= '0;
			entry_count <= '0;
		end else if (resolve_q) begin
			status <= st_c;
			position <= FB'(slot_s1 + 1'b1);
			block_number <= FB'(bn_c);
			entry_count <= FB'(cnt_c);
		end
	end
endmodule

// ----- rtl/core/sktab_ctrl.sv -----
// Command sequencer: capture, compare, resolve and result handshake.
`timescale 1ns / 1ps
module sktab_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic [1:0]       cmd,
	input  sktab_pkg::stat_t stat,
	output sktab_pkg::ctrl_t ctrl
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_RES  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] cmd_q;
	logic       ov_q;

	// A new item may enter while the previous result waits, once it is taken.
	assign in_ready = (state_q == S_IDLE) && (!ov_q || out_ready);
	assign out_valid = ov_q;

	always_comb begin
		ctrl.capture = in_valid && in_ready;
		ctrl.search = (state_q == S_CMP);
		ctrl.do_insert = (state_q == S_RES) && (cmd_q == sktab_pkg::CMD_INSERT) &&
			!stat.full && !stat.hit;
		ctrl.do_delete = (state_q == S_RES) && (cmd_q == sktab_pkg::CMD_DELETE) &&
			stat.hit && stat.nonempty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= sktab_pkg::CMD_LOOKUP;
			ov_q <= 1'b0;
		end else begin
			if (state_q == S_RES) ov_q <= 1'b1;
			else if (out_ready)   ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (ctrl.capture) begin
					state_q <= S_CMP;
					cmd_q <= cmd;
				end
				S_CMP: state_q <= S_RES;
				S_RES: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RES |=> out_valid) else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.do_insert && ctrl.do_delete)) else $error("insert and delete together");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |=> state_q == S_CMP) else $error("capture lost");
endmodule

// ----- bench/sktab_checker.sv -----
// Result checker for the sorted key table: tracks table contents and compares each result.
`timescale 1ns / 1ps
module sktab_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [6:0]  position,
	input  logic [6:0]  block_number,
	input  logic [6:0]  entry_count,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int DEPTH = 64;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] position;
		logic [6:0] block_number;
		logic [6:0] entry_count;
	} answer_t;

	logic [31:0] keys [DEPTH];
	logic [6:0]  blocks [DEPTH + 1];
	int          used;
	logic [6:0]  limit_reg;
	answer_t     answers [$];

	function automatic answer_t apply_command(logic [1:0] op, logic [31:0] k);
		answer_t a;
		int slot;
		int lim;
		bit hit;
		logic [6:0] spare;
		slot = 0;
		while (slot < used && keys[slot] < k)
			slot++;
		hit = slot < used && keys[slot] == k;
		lim = limit_reg > DEPTH ? DEPTH : limit_reg;
		a.status = sktab_pkg::ST_NOT_FOUND;
		a.block_number = '0;
		if (op == sktab_pkg::CMD_INSERT) begin
			if (used >= lim) begin
				a.status = sktab_pkg::ST_FULL;
			end else if (hit) begin
				a.status = sktab_pkg::ST_EXISTS;
				a.block_number = blocks[slot];
			end else begin
				spare = blocks[used];
				for (int i = used; i > slot; i--) begin
					keys[i] = keys[i - 1];
					blocks[i] = blocks[i - 1];
				end
				keys[slot] = k;
				blocks[slot] = spare;
				used++;
				a.status = sktab_pkg::ST_OK;
				a.block_number = spare;
			end
		end else if (op == sktab_pkg::CMD_DELETE) begin
			if (hit) begin
				spare = blocks[slot];
				for (int i = slot; i + 1 < used; i++) begin
					keys[i] = keys[i + 1];
					blocks[i] = blocks[i + 1];
				end
				blocks[used - 1] = spare;
				used--;
				a.status = sktab_pkg::ST_OK;
				a.block_number = spare;
			end
		end else if (hit) begin
			a.status = sktab_pkg::ST_OK;
			a.block_number = blocks[slot];
		end
		a.position = 7'(slot + 1);
		a.entry_count = 7'(used);
		return a;
	endfunction

	assign pending = answers.size();

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			for (int i = 0; i <= DEPTH; i++)
				blocks[i] = 7'(i + 1);
			used = 0;
			limit_reg = 7'd64;
			answers.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{status, position, block_number, entry_count};
				if (answers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = answers.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: status %0d/%0d pos %0d/%0d blk %0d/%0d cnt %0d/%0d",
								want.status, got.status, want.position, got.position,
								want.block_number, got.block_number,
								want.entry_count, got.entry_count);
					end
				end
			end
			if (in_valid && in_ready)
				answers.push_back(apply_command(cmd, key));
			if (cfg_we)
				limit_reg = cfg_data;
		end
	end
endmodule

// ----- bench/sorted_key_table_with_block_pool_tb.sv -----
// Stimulus and verdict for the sorted key table.
`timescale 1ns / 1ps
module sorted_key_table_with_block_pool_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = sktab_pkg::CMD_LOOKUP;
	logic [31:0] key = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [6:0]  position;
	logic [6:0]  block_number;
	logic [6:0]  entry_count;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_data = '0;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	logic [31:0] key_pool [16];
	bit          stall_on = 1'b1;
	int          stall_left = 0;

	always #1 clk = ~clk;

	sorted_key_table_with_block_pool u_top (.*);
	sktab_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int gap_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// Receiver side: stalls of random length, with long stretches of none.
	always @(posedge clk) begin
		if (!stall_on) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= gap_length();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Valid stays high into the next command when there is no gap.
	task automatic send_command(logic [1:0] op, logic [31:0] k, bit with_gap);
		int gap;
		gap = with_gap ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		key <= k;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic set_limit(logic [6:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n, int span);
		logic [1:0] op;
		logic [31:0] k;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 9) < 5) ? sktab_pkg::CMD_INSERT : 2'($urandom_range(0, 3));
			if (op == sktab_pkg::CMD_INSERT && $urandom_range(0, 3) == 0)
				op = sktab_pkg::CMD_DELETE;
			k = ($urandom_range(0, 4) == 0) ? $urandom() : key_pool[$urandom_range(0, span)];
			stall_on = (i / 60) % 3 != 2;
			send_command(op, k, stall_on);
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h5555_5555;
		key_pool[3] = 32'hAAAA_AAAA;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Empty table, then extremes, duplicates, absent deletes, command 3.
		send_command(sktab_pkg::CMD_LOOKUP, 32'h1234, 1'b1);
		send_command(sktab_pkg::CMD_DELETE, 32'h1234, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h0, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h8000_0000, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h0, 1'b1);
		send_command(sktab_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1);
		send_command(sktab_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1);
		send_command(2'd3, 32'h8000_0000, 1'b1);
		send_command(sktab_pkg::CMD_DELETE, 32'h7, 1'b1);
		send_command(sktab_pkg::CMD_DELETE, 32'h0, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h5555_5555, 1'b1);
		send_command(sktab_pkg::CMD_DELETE, 32'hFFFF_FFFF, 1'b1);
		// Zero limit: every insert is full, even of a present key.
		set_limit(7'd0);
		send_command(sktab_pkg::CMD_INSERT, 32'h5555_5555, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h42, 1'b1);
		set_limit(7'd3);
		send_command(sktab_pkg::CMD_INSERT, 32'h42, 1'b1);
		send_command(sktab_pkg::CMD_INSERT, 32'h43, 1'b1);
		send_command(sktab_pkg::CMD_DELETE, 32'h8000_0000, 1'b1);
		set_limit(7'd1);
		random_phase(150, 15);
		set_limit(7'd127);
		random_phase(150, 15);
		// Fill the table to its depth with fresh keys, then churn.
		set_limit(7'd64);
		for (int i = 0; i < 70; i++)
			send_command(sktab_pkg::CMD_INSERT, $urandom(), 1'b1);
		random_phase(100, 15);
		set_limit(7'd65);
		random_phase(200, 15);
		set_limit(7'd8);
		random_phase(150, 7);
		set_limit(7'd40);
		random_phase(200, 15);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
